// File: hw/rtl/ssrbd_pkg.sv
// ----------------------------------------------------------------------------
// ssrbd_pkg
// Shared sizes, types and register codes of the slit-scan row band delay unit.
// ----------------------------------------------------------------------------
package ssrbd_pkg;

    localparam int MAX_COLS    = 64;
    localparam int MAX_ROWS    = 64;
    localparam int RING_FRAMES = 8;
    localparam int PIXEL_BITS  = 24;

    // Band guard: a band is shown only while its band number plus this value stays below the row count.
    localparam int BAND_GUARD  = 4;

    localparam int CFG_W   = 7;
    localparam int IDX_W   = 2;
    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SLOT_W  = (RING_FRAMES > 1) ? $clog2(RING_FRAMES) : 1;
    localparam int SEEN_W  = $clog2(RING_FRAMES + 1);
    localparam int RING_SIZE = RING_FRAMES * MAX_ROWS * MAX_COLS;
    localparam int ADDR_W  = $clog2(RING_SIZE);

    typedef logic [PIXEL_BITS-1:0] t_pixel;
    typedef logic [ADDR_W-1:0]     t_ring_addr;
    typedef logic [CFG_W-1:0]      t_cfg;
    typedef logic [IDX_W-1:0]      t_cfg_idx;

    typedef enum logic [IDX_W-1:0] {
        REG_FRAME_COLS  = 2'd0,
        REG_FRAME_ROWS  = 2'd1,
        REG_BAND_HEIGHT = 2'd2
    } t_reg_idx;

    localparam t_cfg RST_FRAME_COLS  = 7'd64;
    localparam t_cfg RST_FRAME_ROWS  = 7'd64;
    localparam t_cfg RST_BAND_HEIGHT = 7'd4;

endpackage

// File: hw/rtl/ssrbd_if.sv
// ----------------------------------------------------------------------------
// ssrbd interfaces
// Valid/ready channels for pixel input, pixel output and register writes.
// ----------------------------------------------------------------------------
interface ssrbd_in_if;
    logic                  valid;
    logic                  ready;
    ssrbd_pkg::t_pixel     pixel_in;
    logic                  frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface ssrbd_out_if;
    logic                  valid;
    logic                  ready;
    ssrbd_pkg::t_pixel     pixel_out;
    logic                  frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

interface ssrbd_cfg_if;
    logic                  valid;
    logic                  ready;
    ssrbd_pkg::t_cfg_idx   index;
    ssrbd_pkg::t_cfg       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/slit_scan_row_band_delay_unit.sv
// ----------------------------------------------------------------------------
// slit_scan_row_band_delay_unit
// Slit-scan time displacement: each horizontal band of rows shows an older frame.
// ----------------------------------------------------------------------------
// One pixel beat in gives one pixel beat out, in order. The unit takes a beat
// every clock unless back-pressure from the output holds it; each input beat is
// registered first in the middle stage and then in the output register, from
// which it leaves. While a result waits at the output, one more beat is taken
// into the middle stage and then the input stalls until the output beat is taken. The
// rate is set by the frame ring, which does one write (the incoming pixel) and
// one read (the same place in an older frame) per cycle. Rows are grouped into
// bands of band_height rows; band b shows the frame b frames older, and band 0
// the live pixel. A band reads as zero when not enough frames have arrived,
// when it lies past the last whole band, when its band number plus four is
// not below the row count, or when it is deeper than the ring. frame_start
// restarts the position and moves to the next ring slot. The ring is not
// cleared after reset: old-frame reads only reach slots that were written.
// Register writes are accepted whenever the unit is out of reset and belong
// in idle periods.
// ----------------------------------------------------------------------------
module slit_scan_row_band_delay_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssrbd_in_if.sink    i_in,
    ssrbd_out_if.source o_out,
    ssrbd_cfg_if.sink   i_cfg
);

    localparam int CW = ssrbd_pkg::CFG_W;
    localparam int RW = ssrbd_pkg::ROW_W;
    localparam int KW = ssrbd_pkg::COL_W;
    localparam int SW = ssrbd_pkg::SLOT_W;
    localparam int FW = ssrbd_pkg::SEEN_W;
    localparam int AW = ssrbd_pkg::ADDR_W;

    // ---- configuration registers -------------------------------------------
    ssrbd_pkg::t_cfg r_frame_cols, r_frame_rows, r_band_height;

    // Take no register beat while in reset.
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cols  <= ssrbd_pkg::RST_FRAME_COLS;
            r_frame_rows  <= ssrbd_pkg::RST_FRAME_ROWS;
            r_band_height <= ssrbd_pkg::RST_BAND_HEIGHT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ssrbd_pkg::REG_FRAME_COLS:  r_frame_cols  <= i_cfg.data;
                ssrbd_pkg::REG_FRAME_ROWS:  r_frame_rows  <= i_cfg.data;
                ssrbd_pkg::REG_BAND_HEIGHT: r_band_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Clamp register values into their usable range.
    ssrbd_pkg::t_cfg cols_eff, rows_eff, bh_eff;

    always_comb begin
        if (r_frame_cols == '0)
            cols_eff = CW'(1);
        else if (r_frame_cols > CW'(ssrbd_pkg::MAX_COLS))
            cols_eff = CW'(ssrbd_pkg::MAX_COLS);
        else
            cols_eff = r_frame_cols;

        if (r_frame_rows == '0)
            rows_eff = CW'(1);
        else if (r_frame_rows > CW'(ssrbd_pkg::MAX_ROWS))
            rows_eff = CW'(ssrbd_pkg::MAX_ROWS);
        else
            rows_eff = r_frame_rows;

        bh_eff = (r_band_height == '0) ? CW'(1) : r_band_height;
    end

    // ---- position and history state ----------------------------------------
    logic [SW-1:0] r_write_slot;
    logic [FW-1:0] r_frames_seen;
    logic [KW-1:0] r_col_count;
    logic [RW-1:0] r_row_count;
    logic [RW-1:0] r_band_index;
    logic [RW-1:0] r_row_in_band;

    logic          in_acc;

    // Values seen by the current beat (after a frame start has taken effect).
    logic [SW-1:0] cur_slot;
    logic [FW-1:0] cur_seen;
    logic [KW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic [RW-1:0] cur_band;
    logic [RW-1:0] cur_rib;

    // Next state after the beat.
    logic [SW-1:0] n_write_slot;
    logic [FW-1:0] n_frames_seen;
    logic [KW-1:0] n_col_count;
    logic [RW-1:0] n_row_count;
    logic [RW-1:0] n_band_index;
    logic [RW-1:0] n_row_in_band;

    logic              row_last, frame_last;
    logic              band_ok, use_mem;
    logic [RW:0]       band_p1;
    logic [RW+CW:0]    band_span;
    logic [CW:0]       band_guard;
    logic [SW-1:0]     rd_slot;
    logic [SW-1:0]     band_lo;
    ssrbd_pkg::t_ring_addr wr_addr, rd_addr;

    always_comb begin
        if (i_in.frame_start) begin
            cur_slot = (r_write_slot == SW'(ssrbd_pkg::RING_FRAMES - 1)) ?
                       '0 : r_write_slot + SW'(1);
            cur_seen = (r_frames_seen < FW'(ssrbd_pkg::RING_FRAMES)) ?
                       r_frames_seen + FW'(1) : r_frames_seen;
            cur_col  = '0;
            cur_row  = '0;
            cur_band = '0;
            cur_rib  = '0;
        end else begin
            cur_slot = r_write_slot;
            cur_seen = r_frames_seen;
            cur_col  = r_col_count;
            cur_row  = r_row_count;
            cur_band = r_band_index;
            cur_rib  = r_row_in_band;
        end

        // Band validity: (b+1)*bh <= rows stands in for b < rows/bh.
        band_p1    = {1'b0, cur_band} + (RW+1)'(1);
        band_span  = (RW+CW+1)'(band_p1 * bh_eff);
        band_guard = {1'b0, (CW)'(cur_band)} + (CW+1)'(ssrbd_pkg::BAND_GUARD);
        band_ok    = ({{(RW-FW){1'b0}}, cur_seen} > cur_band) &&
                     (band_span <= (RW+CW+1)'(rows_eff)) &&
                     (band_guard < {1'b0, rows_eff}) &&
                     ({1'b0, cur_band} < (RW+1)'(ssrbd_pkg::RING_FRAMES));
        use_mem    = band_ok && (cur_band != '0);

        // Slot b frames back, wrapped around the ring.
        band_lo = SW'(cur_band);
        rd_slot = (band_lo <= cur_slot) ? cur_slot - band_lo :
                  SW'(cur_slot + SW'(ssrbd_pkg::RING_FRAMES) - band_lo);

        wr_addr = AW'((cur_slot * ssrbd_pkg::MAX_ROWS + cur_row) * ssrbd_pkg::MAX_COLS
                      + cur_col);
        rd_addr = AW'((rd_slot * ssrbd_pkg::MAX_ROWS + cur_row) * ssrbd_pkg::MAX_COLS
                      + cur_col);

        row_last   = ({1'b0, (CW-1)'(cur_col)} + CW'(1)) >= cols_eff;
        frame_last = row_last && (({1'b0, (CW-1)'(cur_row)} + CW'(1)) >= rows_eff);

        // Advance the raster position.
        n_write_slot  = cur_slot;
        n_frames_seen = cur_seen;
        n_col_count   = cur_col;
        n_row_count   = cur_row;
        n_band_index  = cur_band;
        n_row_in_band = cur_rib;
        if (!row_last) begin
            n_col_count = cur_col + KW'(1);
        end else if (frame_last) begin
            n_col_count   = '0;
            n_row_count   = '0;
            n_band_index  = '0;
            n_row_in_band = '0;
        end else begin
            n_col_count = '0;
            n_row_count = cur_row + RW'(1);
            if (({1'b0, (CW-1)'(cur_rib)} + CW'(1)) >= bh_eff) begin
                n_row_in_band = '0;
                n_band_index  = cur_band + RW'(1);
            end else begin
                n_row_in_band = cur_rib + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_slot  <= '0;
            r_frames_seen <= '0;
            r_col_count   <= '0;
            r_row_count   <= '0;
            r_band_index  <= '0;
            r_row_in_band <= '0;
        end else if (in_acc) begin
            r_write_slot  <= n_write_slot;
            r_frames_seen <= n_frames_seen;
            r_col_count   <= n_col_count;
            r_row_count   <= n_row_count;
            r_band_index  <= n_band_index;
            r_row_in_band <= n_row_in_band;
        end
    end

    // ---- frame ring ---------------------------------------------------------
    // Band 0 never reads the ring; older bands never hit the slot being written.
    ssrbd_pkg::t_pixel ring_rdata;

    ssrbd_ring u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (wr_addr),
        .i_wdata (i_in.pixel_in),
        .i_re    (in_acc && use_mem),
        .i_raddr (rd_addr),
        .o_rdata (ring_rdata)
    );

    // ---- stage 1: wait for ring read data -----------------------------------
    logic              r_s1_valid;
    ssrbd_pkg::t_pixel r_s1_pix;
    logic              r_s1_ok;
    logic              r_s1_mem;
    logic              r_s1_end;
    logic              s1_adv;

    // ---- output register ----------------------------------------------------
    logic              r_out_valid;
    ssrbd_pkg::t_pixel r_out_pix;
    logic              r_out_end;

    // Take no pixel beat while in reset.
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = i_rst_n && (!r_s1_valid || s1_adv);
    assign in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix <= i_in.pixel_in;
            r_s1_ok  <= band_ok;
            r_s1_mem <= use_mem;
            r_s1_end <= frame_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Select live pixel, older frame, or zero for an unavailable band.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            if (!r_s1_ok)
                r_out_pix <= '0;
            else if (r_s1_mem)
                r_out_pix <= ring_rdata;
            else
                r_out_pix <= r_s1_pix;
            r_out_end <= r_s1_end;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.pixel_out = r_out_pix;
    assign o_out.frame_end = r_out_end;

endmodule

// File: hw/rtl/ssrbd_ring.sv
// ----------------------------------------------------------------------------
// ssrbd_ring
// Frame ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ssrbd_ring (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  ssrbd_pkg::t_ring_addr i_waddr,
    input  ssrbd_pkg::t_pixel     i_wdata,
    input  logic                  i_re,
    input  ssrbd_pkg::t_ring_addr i_raddr,
    output ssrbd_pkg::t_pixel     o_rdata
);

    ssrbd_pkg::t_pixel r_mem [ssrbd_pkg::RING_SIZE];
    ssrbd_pkg::t_pixel r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read so a stalled stage keeps it.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the slit-scan row band delay unit.
// ----------------------------------------------------------------------------
// Pixel beats go in through a queue-fed driver and come out through a
// monitor that matches them in order against a running prediction. The
// prediction keeps its own frame ring, position counters and register copies.
// A planning copy of the same state steers the stimulus so that no old-frame
// read ever lands on a ring entry that was never written. The run is a short
// directed part, then phases of mostly whole frames under changing register
// settings, with random idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 48;
    localparam int HOLD_CYCLES = 64;

    // Scan position, ring bookkeeping and raw register copies.
    typedef struct {
        logic [ssrbd_pkg::SLOT_W-1:0] slot;
        logic [ssrbd_pkg::SEEN_W-1:0] seen;
        logic [ssrbd_pkg::COL_W-1:0]  col;
        logic [ssrbd_pkg::ROW_W-1:0]  row;
        logic [ssrbd_pkg::ROW_W-1:0]  band;
        logic [ssrbd_pkg::ROW_W-1:0]  row_in_band;
        ssrbd_pkg::t_cfg              cols;
        ssrbd_pkg::t_cfg              rows;
        ssrbd_pkg::t_cfg              bh;
    } t_scan_state;

    typedef struct {
        ssrbd_pkg::t_pixel pixel;
        bit                start;
    } t_scan_in;

    typedef struct {
        ssrbd_pkg::t_pixel pixel;
        logic              frame_end;
    } t_scan_out;

    logic i_clk;
    logic i_rst_n;

    ssrbd_in_if  in_if ();
    ssrbd_out_if out_if ();
    ssrbd_cfg_if cfg_if ();

    slit_scan_row_band_delay_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Predicted state follows accepted beats; planned state follows queued ones.
    t_scan_state       scan_now;
    t_scan_state       scan_plan;
    ssrbd_pkg::t_pixel scan_ring [ssrbd_pkg::RING_SIZE];
    bit                plan_written [ssrbd_pkg::RING_SIZE];

    t_scan_in    pixel_queue [$];
    t_scan_out   displaced_q [$];

    int items_queued = 0;
    int results_seen = 0;
    int errors       = 0;
    int in_gap       = 0;
    int out_gap      = 0;
    int hold_left    = 0;
    bit in_taken     = 1'b0;
    bit steady       = 1'b0;
    bit hold_off_req = 1'b0;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic int eff_dim(input ssrbd_pkg::t_cfg v, input int hi);
        if (v == '0) return 1;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    function automatic int eff_band(input ssrbd_pkg::t_cfg v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    function automatic int ring_index(input int slot, input int row, input int col);
        return (slot * ssrbd_pkg::MAX_ROWS + row) * ssrbd_pkg::MAX_COLS + col;
    endfunction

    function automatic void clear_scan(inout t_scan_state s);
        s.slot        = '0;
        s.seen        = '0;
        s.col         = '0;
        s.row         = '0;
        s.band        = '0;
        s.row_in_band = '0;
        s.cols        = ssrbd_pkg::RST_FRAME_COLS;
        s.rows        = ssrbd_pkg::RST_FRAME_ROWS;
        s.bh          = ssrbd_pkg::RST_BAND_HEIGHT;
    endfunction

    function automatic void set_reg(inout t_scan_state s, input ssrbd_pkg::t_reg_idx idx,
                                    input ssrbd_pkg::t_cfg v);
        case (idx)
            ssrbd_pkg::REG_FRAME_COLS:  s.cols = v;
            ssrbd_pkg::REG_FRAME_ROWS:  s.rows = v;
            ssrbd_pkg::REG_BAND_HEIGHT: s.bh   = v;
            default: ;
        endcase
    endfunction

    // A frame start moves to the next ring slot and restarts the position.
    function automatic void open_pixel(inout t_scan_state s, input bit start);
        if (start) begin
            s.slot = ssrbd_pkg::SLOT_W'((int'(s.slot) + 1) % ssrbd_pkg::RING_FRAMES);
            if (int'(s.seen) < ssrbd_pkg::RING_FRAMES) s.seen = s.seen + 1'b1;
            s.col         = '0;
            s.row         = '0;
            s.band        = '0;
            s.row_in_band = '0;
        end
    endfunction

    // Tell whether the current band shows a stored frame, and which slot.
    function automatic bit band_source(input t_scan_state s, output int src);
        int  rows;
        int  b;
        bit  shown;
        rows  = eff_dim(s.rows, ssrbd_pkg::MAX_ROWS);
        b     = int'(s.band);
        shown = b < int'(s.seen) && b < rows / eff_band(s.bh) &&
                b + ssrbd_pkg::BAND_GUARD < rows && b < ssrbd_pkg::RING_FRAMES;
        src   = shown ? (int'(s.slot) + ssrbd_pkg::RING_FRAMES - b) % ssrbd_pkg::RING_FRAMES
                      : 0;
        return shown;
    endfunction

    // Advance past the current pixel; a counter already past a lowered
    // register ends its row or frame at once.
    function automatic bit close_pixel(inout t_scan_state s);
        int cols;
        int rows;
        bit row_last;
        bit frame_last;
        cols       = eff_dim(s.cols, ssrbd_pkg::MAX_COLS);
        rows       = eff_dim(s.rows, ssrbd_pkg::MAX_ROWS);
        row_last   = int'(s.col) + 1 >= cols;
        frame_last = row_last && int'(s.row) + 1 >= rows;
        if (!row_last) begin
            s.col = s.col + 1'b1;
        end else if (frame_last) begin
            s.col         = '0;
            s.row         = '0;
            s.band        = '0;
            s.row_in_band = '0;
        end else begin
            s.col         = '0;
            s.row         = s.row + 1'b1;
            s.row_in_band = s.row_in_band + 1'b1;
            if (int'(s.row_in_band) >= eff_band(s.bh)) begin
                s.row_in_band = '0;
                s.band        = s.band + 1'b1;
            end
        end
        return frame_last;
    endfunction

    // Store the live pixel, then fetch the same place from the band's frame.
    function automatic t_scan_out displace_pixel(input ssrbd_pkg::t_pixel pix,
                                                 input bit start);
        t_scan_out r;
        int        src;
        open_pixel(scan_now, start);
        scan_ring[ring_index(scan_now.slot, scan_now.row, scan_now.col)] = pix;
        if (band_source(scan_now, src))
            r.pixel = scan_ring[ring_index(src, scan_now.row, scan_now.col)];
        else
            r.pixel = '0;
        r.frame_end = close_pixel(scan_now);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus planning
    // ------------------------------------------------------------------------
    function automatic ssrbd_pkg::t_pixel rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return ssrbd_pkg::t_pixel'($urandom);
        endcase
    endfunction

    // Queue one beat. Force a frame start where the band would read a ring
    // entry that no frame has written yet.
    function automatic void queue_pixel(input ssrbd_pkg::t_pixel pix, input bit start);
        t_scan_state probe;
        int          src;
        bit          go;
        go    = start;
        probe = scan_plan;
        open_pixel(probe, go);
        if (band_source(probe, src) && src != int'(probe.slot) &&
            !plan_written[ring_index(src, probe.row, probe.col)])
            go = 1'b1;
        open_pixel(scan_plan, go);
        plan_written[ring_index(scan_plan.slot, scan_plan.row, scan_plan.col)] = 1'b1;
        void'(close_pixel(scan_plan));
        pixel_queue.push_back('{pix, go});
        items_queued++;
    endfunction

    // Mostly whole frames, with some noise, cut-short frames and frames that
    // wrap without a start beat.
    task automatic fill_phase(input int target);
        int sent;
        int area;
        int kind;
        int len;
        bit start;
        sent = 0;
        area = eff_dim(scan_plan.cols, ssrbd_pkg::MAX_COLS) *
               eff_dim(scan_plan.rows, ssrbd_pkg::MAX_ROWS);
        while (sent < target) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0:       len = $urandom_range(1, 8);
                1:       len = (area > 1) ? $urandom_range(1, area - 1) : 1;
                default: len = area;
            endcase
            for (int i = 0; i < len; i++) begin
                case (kind)
                    0:       start = ($urandom_range(0, 3) == 0);
                    2:       start = 1'b0;
                    default: start = (i == 0);
                endcase
                queue_pixel(rand_pixel(), start);
            end
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Register writes and phase control
    // ------------------------------------------------------------------------
    task automatic write_reg(input ssrbd_pkg::t_reg_idx idx, input ssrbd_pkg::t_cfg v);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        set_reg(scan_now, idx, v);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic apply_config(input ssrbd_pkg::t_cfg c, input ssrbd_pkg::t_cfg r,
                                input ssrbd_pkg::t_cfg h);
        write_reg(ssrbd_pkg::REG_FRAME_COLS, c);
        write_reg(ssrbd_pkg::REG_FRAME_ROWS, r);
        write_reg(ssrbd_pkg::REG_BAND_HEIGHT, h);
        set_reg(scan_plan, ssrbd_pkg::REG_FRAME_COLS, c);
        set_reg(scan_plan, ssrbd_pkg::REG_FRAME_ROWS, r);
        set_reg(scan_plan, ssrbd_pkg::REG_BAND_HEIGHT, h);
    endtask

    // Hold the sender until every queued beat has come back out.
    task automatic wait_drained();
        while (pixel_queue.size() != 0 || results_seen != items_queued)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: advance at the falling edge once the last beat was taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (in_gap > 0) begin
                // Finish the current idle burst.
                in_gap      <= in_gap - 1;
                in_if.valid <= 1'b0;
            end else if (pixel_queue.size() != 0 && !steady && $urandom_range(0, 7) == 0) begin
                // Open an idle burst.
                in_gap      <= $urandom_range(0, 3);
                in_if.valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
                in_if.valid       <= 1'b1;
                in_if.pixel_in    <= pixel_queue[0].pixel;
                in_if.frame_start <= pixel_queue[0].start;
                void'(pixel_queue.pop_front());
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output back-pressure: one long hold-off on request, else short bursts
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else if (hold_off_req) begin
            // Hold long enough that the unit fills and stalls its input.
            hold_off_req = 1'b0;
            hold_left    <= HOLD_CYCLES - 1;
            out_if.ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap      <= out_gap - 1;
            out_if.ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 5) == 0) begin
            out_gap      <= $urandom_range(0, 3);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Beat sampling at the rising edge: predict on input, check on output
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_scan_out want;
        in_taken = 1'b0;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            displaced_q.push_back(displace_pixel(in_if.pixel_in, in_if.frame_start));
            in_taken = 1'b1;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (displaced_q.size() == 0) begin
                $error("unexpected beat: pixel_out %h frame_end %b",
                       out_if.pixel_out, out_if.frame_end);
                errors++;
            end else begin
                want = displaced_q.pop_front();
                if (out_if.pixel_out !== want.pixel) begin
                    $error("pixel_out: expected %h, actual %h", want.pixel, out_if.pixel_out);
                    errors++;
                end
                if (out_if.frame_end !== want.frame_end) begin
                    $error("frame_end: expected %b, actual %b",
                           want.frame_end, out_if.frame_end);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        ssrbd_pkg::t_cfg c;
        ssrbd_pkg::t_cfg r;
        ssrbd_pkg::t_cfg h;

        in_if.valid       = 1'b0;
        in_if.pixel_in    = '0;
        in_if.frame_start = 1'b0;
        out_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = ssrbd_pkg::REG_FRAME_COLS;
        cfg_if.data       = '0;
        i_rst_n           = 1'b0;
        clear_scan(scan_now);
        clear_scan(scan_plan);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Pixels ahead of any frame start come out as zero; after the first
        // start, band 0 passes the live pixel straight through.
        queue_pixel(24'h000000, 1'b0);
        queue_pixel(24'hFFFFFF, 1'b0);
        queue_pixel(24'h123456, 1'b0);
        queue_pixel(24'hA5A5A5, 1'b1);
        queue_pixel(24'h5A5A5A, 1'b0);
        queue_pixel(24'hFFFFFF, 1'b0);
        wait_drained();

        // Zero width acts as one column, so the row in progress ends at once.
        // Six rows of one-row bands leave band 1 showing the previous frame.
        apply_config(7'd0, 7'd6, 7'd1);
        queue_pixel(24'hC0FFEE, 1'b0);
        for (int f = 0; f < 3; f++) begin
            for (int i = 0; i < 6; i++)
                queue_pixel(((i + f) % 2 != 0) ? 24'hFFFFFF : 24'h000000, i == 0);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin c = 7'd127; r = 7'd1;   h = 7'd127; end
                1: begin c = 7'd1;   r = 7'd127; h = 7'd4;   end
                2: begin c = 7'd0;   r = 7'd64;  h = 7'd64;  end
                3: begin c = 7'd4;   r = 7'd0;   h = 7'd0;   end
                4: begin c = 7'd64;  r = 7'd1;   h = 7'd1;   end
                default: begin
                    if ($urandom_range(0, 2) != 0) begin
                        // Deep setting: many short bands in a small frame.
                        c = ssrbd_pkg::t_cfg'($urandom_range(1, 6));
                        r = ssrbd_pkg::t_cfg'($urandom_range(6, 20));
                        h = ssrbd_pkg::t_cfg'($urandom_range(1, 3));
                    end else begin
                        c = ssrbd_pkg::t_cfg'($urandom_range(0, 127));
                        r = ssrbd_pkg::t_cfg'($urandom_range(0, 127));
                        h = ssrbd_pkg::t_cfg'($urandom_range(0, 127));
                        if (eff_dim(c, ssrbd_pkg::MAX_COLS) *
                            eff_dim(r, ssrbd_pkg::MAX_ROWS) > 128)
                            c = ssrbd_pkg::t_cfg'($urandom_range(0, 2));
                    end
                end
            endcase
            apply_config(c, r, h);
            steady = (p >= NUM_PHASES - 2);
            fill_phase(PHASE_ITEMS);
            if (p == 1) hold_off_req = 1'b1;
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Drop the run if it hangs.
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
